>>> hw/rtl/nsld_pkg.sv
// ----------------------------------------------------------------------------
// nsld_pkg
// Types and constants shared by the noise-shaped linear dither block.
// ----------------------------------------------------------------------------
package nsld_pkg;

  localparam int SAMPLE_W = 32;
  // The front-end sum holds sample + rounding bias + dither, with room to spare.
  localparam int BASE_W   = 34;
  // Back-end accumulator width; no sum of the datapath can wrap at this width.
  localparam int ACC_W    = 36;
  localparam int ERR_W    = 32;
  localparam int LCG_W    = 32;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'h0019_660d;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'h3c6e_f35f;

  // One request as it travels from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [BASE_W-1:0]   base;
  } item_t;

  // Queue status toward the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

>>> hw/rtl/noise_shaped_linear_dither.sv
// ----------------------------------------------------------------------------
// noise_shaped_linear_dither
// Noise-shaped, triangular-dithered conversion of fixed-point samples to PCM.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the queue is not full and returns
// one PCM result per sample, in order; each request passes through the queue
// and the result register. The rate is set by the back end, where the
// three-tap error-feedback loop, clipping and quantization close per sample;
// the dither generator runs one step ahead in the front end so that its
// multiplier feeds a register only. A two-entry queue between front and back
// and the result register let input and output stall independently. Reset
// clears all state but the data registers; no clearing pass is needed.
module noise_shaped_linear_dither
  import nsld_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int OUT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [OUT_BITS-1:0] pcm_out,
  output logic                       was_clipped,
  output logic [FRAC_BITS:0]         peak_level,
  output logic [31:0]                clip_count,
  output logic [31:0]                peak_overshoot
);

  localparam int SCALE_RAW  = FRAC_BITS + 1 - OUT_BITS;
  localparam int SCALE_BITS = (SCALE_RAW < 1) ? 1 : SCALE_RAW;
  localparam int PEAK_W     = FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] FULL_ONE  = ACC_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] STEP_MASK = (ACC_W'(1) << SCALE_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Q_HI      = (FULL_ONE - ACC_W'(1)) & ~STEP_MASK;
  localparam logic signed [ACC_W-1:0] Q_LO      = -FULL_ONE;
  localparam logic [OUT_BITS-1:0] PCM_HI = Q_HI[SCALE_BITS+OUT_BITS-1:SCALE_BITS];
  localparam logic [OUT_BITS-1:0] PCM_LO = Q_LO[SCALE_BITS+OUT_BITS-1:SCALE_BITS];
  localparam logic [PEAK_W-1:0]   PEAK_CAP = PEAK_W'(1) << FRAC_BITS;

  logic        accept;
  logic        queue_full;
  logic        pop;
  item_t       front_item;
  queue_head_t head;
  logic [OUT_BITS-1:0] pcm_bits;

  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;

  nsld_front #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample_in (sample_in),
    .item      (front_item)
  );

  nsld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  nsld_back #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .pcm_out        (pcm_bits),
    .was_clipped    (was_clipped),
    .peak_level     (peak_level),
    .clip_count     (clip_count),
    .peak_overshoot (peak_overshoot)
  );

  assign pcm_out = signed'(pcm_bits);

  // A clipped sample always lands on one of the two full-scale codes.
  a_clip_full_scale: assert property (@(posedge clk) disable iff (rst)
    result_valid && was_clipped |-> pcm_bits == PCM_HI || pcm_bits == PCM_LO)
    else $error("clipped sample not at full scale");

  // Consecutive results: the clip count advances by exactly the clip flag.
  a_clip_count_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall ##1 result_valid
      |-> clip_count == $past(clip_count) + 32'(was_clipped))
    else $error("clip count does not follow the clip flags");

  // The tracked peak never exceeds full scale.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> peak_level <= PEAK_CAP)
    else $error("peak level beyond full scale");

endmodule

>>> hw/rtl/nsld_front.sv
// ----------------------------------------------------------------------------
// nsld_front
// Front end: runs the dither generator and adds bias and dither to a request.
// ----------------------------------------------------------------------------
module nsld_front
  import nsld_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int OUT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output item_t                      item
);

  localparam int SCALE_RAW  = FRAC_BITS + 1 - OUT_BITS;
  localparam int SCALE_BITS = (SCALE_RAW < 1) ? 1 : SCALE_RAW;
  localparam logic signed [BASE_W-1:0] BIAS = BASE_W'(1) << (SCALE_BITS - 1);

  // The generator value used by the current request and the one after it.
  // The sequence does not depend on the data, so the multiply runs a step ahead.
  logic [LCG_W-1:0] lcg_cur;
  logic [LCG_W-1:0] lcg_ahead;
  logic [LCG_W-1:0] lcg_ahead_next;

  logic signed [BASE_W-1:0] base;

  assign lcg_ahead_next = lcg_ahead * LCG_MUL + LCG_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_cur   <= '0;
      lcg_ahead <= LCG_ADD;
    end else if (accept) begin
      lcg_cur   <= lcg_ahead;
      lcg_ahead <= lcg_ahead_next;
    end
  end

  // Triangular dither: difference of the low bits of two successive values.
  assign base = BASE_W'(sample_in) + BIAS
              + BASE_W'(lcg_ahead[SCALE_BITS-1:0])
              - BASE_W'(lcg_cur[SCALE_BITS-1:0]);

  assign item = '{sample: sample_in, base: base};

endmodule

>>> hw/rtl/nsld_queue.sv
// ----------------------------------------------------------------------------
// nsld_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module nsld_queue
  import nsld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

endmodule

>>> hw/rtl/nsld_back.sv
// ----------------------------------------------------------------------------
// nsld_back
// Back end: error feedback, clipping, quantization, statistics, result register.
// ----------------------------------------------------------------------------
module nsld_back
  import nsld_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int OUT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_head_t           head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [OUT_BITS-1:0]   pcm_out,
  output logic                  was_clipped,
  output logic [FRAC_BITS:0]    peak_level,
  output logic [31:0]           clip_count,
  output logic [31:0]           peak_overshoot
);

  localparam int SCALE_RAW  = FRAC_BITS + 1 - OUT_BITS;
  localparam int SCALE_BITS = (SCALE_RAW < 1) ? 1 : SCALE_RAW;
  localparam int PEAK_W     = FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] FULL_ONE  = ACC_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] LIM_MAX   = FULL_ONE - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LIM_MIN   = -FULL_ONE;
  localparam logic signed [ACC_W-1:0] STEP_MASK = (ACC_W'(1) << SCALE_BITS) - ACC_W'(1);

  logic signed [ERR_W-1:0] err_newest;
  logic signed [ERR_W-1:0] err_half;
  logic signed [ERR_W-1:0] err_oldest;
  logic [PEAK_W-1:0]       peak_track;
  logic [31:0]             clip_total;
  logic [31:0]             overshoot_max;

  logic signed [ACC_W-1:0] feedback;
  logic signed [ACC_W-1:0] shaped;
  logic signed [ACC_W-1:0] level;
  logic signed [ACC_W-1:0] peak_s;
  logic signed [ACC_W-1:0] level_clip;
  logic signed [ACC_W-1:0] level_neg;
  logic signed [ACC_W-1:0] shaped_clip;
  logic signed [ACC_W-1:0] quant;
  logic signed [ACC_W-1:0] err_diff;
  logic [ACC_W-1:0]        over;
  logic signed [ERR_W:0]   half_sum;
  logic                    over_hi;
  logic                    over_lo;
  logic                    clipped;
  logic [PEAK_W-1:0]       peak_track_next;
  logic [31:0]             clip_total_next;
  logic [31:0]             overshoot_max_next;

  assign pop = head.valid && (!result_valid || !result_stall);

  always_comb begin
    feedback = ACC_W'(err_newest) - ACC_W'(err_half) + ACC_W'(err_oldest);
    shaped   = ACC_W'(head.item.sample) + feedback;
    level    = ACC_W'(head.item.base) + feedback;
    peak_s   = ACC_W'(peak_track);

    over_hi = (level > LIM_MAX);
    over_lo = (level < LIM_MIN);
    clipped = over_hi || over_lo;

    level_clip  = level;
    shaped_clip = shaped;
    over        = '0;
    if (over_hi) begin
      level_clip = LIM_MAX;
      over       = level - LIM_MAX;
      if (shaped > LIM_MAX) begin
        shaped_clip = LIM_MAX;
      end
    end else if (over_lo) begin
      level_clip = LIM_MIN;
      over       = LIM_MIN - level;
      if (shaped < LIM_MIN) begin
        shaped_clip = LIM_MIN;
      end
    end
    level_neg = -level_clip;

    // A positive level updates the peak when it reaches it; a negative one
    // only when it lies strictly beyond it.
    peak_track_next = peak_track;
    if (level >= peak_s) begin
      peak_track_next = level_clip[PEAK_W-1:0];
    end else if (level < -peak_s) begin
      peak_track_next = level_neg[PEAK_W-1:0];
    end

    clip_total_next    = clip_total + 32'(clipped);
    overshoot_max_next = overshoot_max;
    if (clipped && (over > ACC_W'(overshoot_max))) begin
      overshoot_max_next = over[31:0];
    end

    quant    = level_clip & ~STEP_MASK;
    err_diff = shaped_clip - quant;

    // Halving rounds toward zero: add one to negative values before the shift.
    half_sum = (ERR_W + 1)'(err_newest) + (ERR_W + 1)'(err_newest[ERR_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_newest    <= '0;
      err_half      <= '0;
      err_oldest    <= '0;
      peak_track    <= '0;
      clip_total    <= '0;
      overshoot_max <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        err_oldest    <= err_half;
        err_half      <= half_sum[ERR_W:1];
        err_newest    <= err_diff[ERR_W-1:0];
        peak_track    <= peak_track_next;
        clip_total    <= clip_total_next;
        overshoot_max <= overshoot_max_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pcm_out        <= quant[SCALE_BITS+OUT_BITS-1:SCALE_BITS];
      was_clipped    <= clipped;
      peak_level     <= peak_track_next;
      clip_count     <= clip_total_next;
      peak_overshoot <= overshoot_max_next;
    end
  end

endmodule
